[hw/rtl/fircrc_pkg.sv]
`default_nettype none

package fircrc_pkg;

  localparam int SIZE_WIDTH      = 27;
  localparam int OFFSET_WIDTH    = 26;
  localparam int TIMEOUT_WIDTH   = 16;
  localparam int ELAPSED_WIDTH   = 17;
  localparam int CFG_IDX_WIDTH   = 2;
  localparam int BLOCK_BYTES_DEF = 4096;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] MAGIC_WORD = 32'h2141_544F;  // "OTA!" little-endian

  localparam logic [SIZE_WIDTH-1:0]    MAX_SIZE_RST  = 27'd67108864;
  localparam logic [TIMEOUT_WIDTH-1:0] MAGIC_TO_RST  = 16'd60000;
  localparam logic [TIMEOUT_WIDTH-1:0] FIELD_TO_RST  = 16'd5000;
  localparam logic [TIMEOUT_WIDTH-1:0] BLOCK_TO_RST  = 16'd30000;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_SIZE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAGIC_TO = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FIELD_TO = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BLOCK_TO = 2'd3;

  // request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // verdict codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MAGIC_TO  = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_SIZE_TO   = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
  localparam logic [2:0] ST_DATA_TO   = 3'd5;
  localparam logic [2:0] ST_CRC_TO    = 3'd6;
  localparam logic [2:0] ST_CRC_BAD   = 3'd7;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                    out_kind;
    logic [7:0]              data_byte;
    logic [OFFSET_WIDTH-1:0] byte_offset;
    logic [2:0]              status_code;
    logic [SIZE_WIDTH-1:0]   frame_size;
    logic [31:0]             crc_value;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_WIDTH-1:0]    max_frame_size;
    logic [TIMEOUT_WIDTH-1:0] magic_timeout_ms;
    logic [TIMEOUT_WIDTH-1:0] field_timeout_ms;
    logic [TIMEOUT_WIDTH-1:0] block_timeout_ms;
  } cfg_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/framed_image_receiver_crc32_core.sv]
`default_nettype none

// Framed image receiver: takes a stream of beats, each either a received byte
// or a one-millisecond tick, and parses frames of "OTA!", a little-endian
// 32-bit size, the payload and a little-endian CRC-32 of the payload.
// Channels: in_* (valid/ready, in_item_t) and out_* (valid/ready, out_item_t).
// Each payload byte comes out as a data beat with its offset; every frame
// attempt ends in one verdict beat (ok, a phase timeout, bad magic, bad size,
// crc mismatch). Ticks and header bytes give no output unless they end a frame.
// A result passes the input register, then the parse/CRC step into the
// output register; the parse step waits while the skid entry is full.
// Throughput: one beat per clock while the skid entry is free; the frame
// state and a byte-wide CRC update sit in one stage between the input
// register and the output register. A skid entry behind the output register
// lets the block take one more beat while out_ready is low; in_ready drops
// once that entry and the input register are both occupied.
// cfg_we writes register cfg_index with cfg_wdata in the same clock; write
// only while idle. Reset (rst_n low, synchronous) empties the pipeline,
// restores the register defaults and restarts the parser at the magic.
module framed_image_receiver_crc32_core import fircrc_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_item_t                     out_data,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [SIZE_WIDTH-1:0]    cfg_wdata
);

  cfg_t      cfg_r;
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  logic      skid_vld_r;
  out_item_t skid_item_r;

  logic      eng_step;
  logic      res_vld;
  out_item_t res;
  logic      in_fire;
  logic      out_pop;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_size   <= MAX_SIZE_RST;
      cfg_r.magic_timeout_ms <= MAGIC_TO_RST;
      cfg_r.field_timeout_ms <= FIELD_TO_RST;
      cfg_r.block_timeout_ms <= BLOCK_TO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SIZE: cfg_r.max_frame_size   <= cfg_wdata;
        REG_MAGIC_TO: cfg_r.magic_timeout_ms <= cfg_wdata[TIMEOUT_WIDTH-1:0];
        REG_FIELD_TO: cfg_r.field_timeout_ms <= cfg_wdata[TIMEOUT_WIDTH-1:0];
        REG_BLOCK_TO: cfg_r.block_timeout_ms <= cfg_wdata[TIMEOUT_WIDTH-1:0];
        default:      cfg_r.max_frame_size   <= cfg_r.max_frame_size;
      endcase
    end
  end

  // the parse step runs whenever a beat sits in the input register and
  // there is room for its possible result (skid entry free)
  assign eng_step = in_vld_r && !skid_vld_r;
  assign in_ready = !in_vld_r || eng_step;
  assign in_fire  = in_valid && in_ready;
  assign out_pop  = out_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= in_data;
    end
  end

  fircrc_engine #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step    (eng_step),
    .item    (in_item_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_pop) begin
        out_item_r <= skid_item_r;
        skid_vld_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (!out_vld_r || out_pop) begin
        out_item_r <= res;
        out_vld_r  <= 1'b1;
      end else begin
        skid_item_r <= res;
        skid_vld_r  <= 1'b1;
      end
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !res_vld)
    else $error("result produced with no room");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(out_item_r))
    else $error("output beat changed while stalled");

endmodule

`default_nettype wire

[hw/rtl/fircrc_engine.sv]
`default_nettype none

module fircrc_engine import fircrc_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      step,
  input  wire in_item_t  item,
  output logic           res_vld,
  output out_item_t      res
);

  localparam int BLK_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam logic [BLK_W:0] BLK_LAST = (BLK_W + 1)'(BLOCK_BYTES);

  localparam logic [1:0] PH_MAGIC = 2'd0;
  localparam logic [1:0] PH_SIZE  = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_CRC   = 2'd3;

  localparam logic [ELAPSED_WIDTH-1:0] EL_MAX = '1;

  logic [1:0]               phase_r,    phase_nxt;
  logic [1:0]               fidx_r,     fidx_nxt;
  logic [23:0]              shift_r,    shift_nxt;
  logic [SIZE_WIDTH-1:0]    decl_r,     decl_nxt;
  logic [SIZE_WIDTH-1:0]    rcv_r,      rcv_nxt;
  logic [BLK_W-1:0]         blk_r,      blk_nxt;
  logic [31:0]              crc_r,      crc_nxt;
  logic [ELAPSED_WIDTH-1:0] elapsed_r,  elapsed_nxt;

  logic [ELAPSED_WIDTH-1:0] el_inc;
  logic [TIMEOUT_WIDTH-1:0] limit;
  logic [2:0]               to_code;
  logic [SIZE_WIDTH-1:0]    to_size;
  logic [31:0]              word;
  logic [SIZE_WIDTH-1:0]    rcv_inc;
  logic [BLK_W:0]           blk_inc;
  logic                     verdict;
  logic [2:0]               v_code;
  logic [SIZE_WIDTH-1:0]    v_size;

  always_comb begin
    el_inc  = (elapsed_r == EL_MAX) ? elapsed_r : elapsed_r + 1'b1;
    word    = {item.rx_byte, shift_r};
    rcv_inc = rcv_r + 1'b1;
    blk_inc = {1'b0, blk_r} + 1'b1;

    unique case (phase_r)
      PH_MAGIC: begin
        limit   = cfg.magic_timeout_ms;
        to_code = ST_MAGIC_TO;
        to_size = '0;
      end
      PH_SIZE: begin
        limit   = cfg.field_timeout_ms;
        to_code = ST_SIZE_TO;
        to_size = '0;
      end
      PH_DATA: begin
        limit   = cfg.block_timeout_ms;
        to_code = ST_DATA_TO;
        to_size = decl_r;
      end
      default: begin
        limit   = cfg.field_timeout_ms;
        to_code = ST_CRC_TO;
        to_size = decl_r;
      end
    endcase

    phase_nxt   = phase_r;
    fidx_nxt    = fidx_r;
    shift_nxt   = shift_r;
    decl_nxt    = decl_r;
    rcv_nxt     = rcv_r;
    blk_nxt     = blk_r;
    crc_nxt     = crc_r;
    elapsed_nxt = elapsed_r;
    verdict     = 1'b0;
    v_code      = ST_OK;
    v_size      = '0;
    res_vld     = 1'b0;
    res         = '0;

    if (step) begin
      if (item.req_type == REQ_TICK) begin
        elapsed_nxt = el_inc;
        if (el_inc > {1'b0, limit}) begin
          verdict = 1'b1;
          v_code  = to_code;
          v_size  = to_size;
        end
      end else if (phase_r == PH_DATA) begin
        crc_nxt         = crc32_byte(crc_r, item.rx_byte);
        res_vld         = 1'b1;
        res.out_kind    = KIND_DATA;
        res.data_byte   = item.rx_byte;
        res.byte_offset = rcv_r[OFFSET_WIDTH-1:0];
        rcv_nxt         = rcv_inc;
        blk_nxt         = blk_inc[BLK_W-1:0];
        if (rcv_inc >= decl_r) begin
          blk_nxt     = '0;
          phase_nxt   = PH_CRC;
          fidx_nxt    = '0;
          shift_nxt   = '0;
          elapsed_nxt = '0;
        end else if (blk_inc == BLK_LAST) begin
          blk_nxt     = '0;
          elapsed_nxt = '0;
        end
      end else begin
        fidx_nxt = fidx_r + 1'b1;
        case (fidx_r)
          2'd0:    shift_nxt[7:0]   = item.rx_byte;
          2'd1:    shift_nxt[15:8]  = item.rx_byte;
          2'd2:    shift_nxt[23:16] = item.rx_byte;
          default: shift_nxt        = shift_r;
        endcase
        if (fidx_r == 2'd3) begin
          shift_nxt   = '0;
          elapsed_nxt = '0;
          unique case (phase_r)
            PH_MAGIC: begin
              if (word != MAGIC_WORD) begin
                verdict = 1'b1;
                v_code  = ST_BAD_MAGIC;
              end else begin
                phase_nxt = PH_SIZE;
              end
            end
            PH_SIZE: begin
              if (word == '0 || word > {{(32-SIZE_WIDTH){1'b0}}, cfg.max_frame_size}) begin
                verdict = 1'b1;
                v_code  = ST_BAD_SIZE;
                v_size  = (|word[31:SIZE_WIDTH]) ? '1 : word[SIZE_WIDTH-1:0];
              end else begin
                decl_nxt  = word[SIZE_WIDTH-1:0];
                rcv_nxt   = '0;
                blk_nxt   = '0;
                crc_nxt   = '1;
                phase_nxt = PH_DATA;
              end
            end
            default: begin
              verdict = 1'b1;
              v_code  = (word == ~crc_r) ? ST_OK : ST_CRC_BAD;
              v_size  = decl_r;
            end
          endcase
        end
      end

      if (verdict) begin
        res_vld         = 1'b1;
        res.out_kind    = KIND_VERDICT;
        res.status_code = v_code;
        res.frame_size  = v_size;
        res.crc_value   = ~crc_r;
        // restart at the magic
        phase_nxt   = PH_MAGIC;
        fidx_nxt    = '0;
        shift_nxt   = '0;
        decl_nxt    = '0;
        rcv_nxt     = '0;
        blk_nxt     = '0;
        crc_nxt     = '1;
        elapsed_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC;
      fidx_r    <= '0;
      shift_r   <= '0;
      decl_r    <= '0;
      rcv_r     <= '0;
      blk_r     <= '0;
      crc_r     <= '1;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      fidx_r    <= fidx_nxt;
      shift_r   <= shift_nxt;
      decl_r    <= decl_nxt;
      rcv_r     <= rcv_nxt;
      blk_r     <= blk_nxt;
      crc_r     <= crc_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  a_verdict_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.out_kind == KIND_VERDICT |=> phase_r == PH_MAGIC && crc_r == '1 && fidx_r == '0)
    else $error("frame state not restarted after verdict");

  a_blk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, blk_r} < BLK_LAST)
    else $error("block counter past block size");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> rcv_r < decl_r)
    else $error("payload count reached declared size inside data phase");

  a_blk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_DATA |-> blk_r == '0 && rcv_r == '0 || phase_r == PH_CRC)
    else $error("payload counters live outside payload");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import fircrc_pkg::*;

  localparam int WATCHDOG_CYCLES = 2_000_000;
  localparam int WHOLE_FRAME     = 1 << 30;   // cut point that never truncates
  localparam int PIPE_SETTLE     = 6;         // settle margin for beats still in the pipeline

  typedef enum logic [1:0] {RX_MAGIC, RX_SIZE, RX_DATA, RX_CRC} rx_phase_e;

  // Mirror of the deframer: tracks parser state and queues the beats it must emit.
  class frame_scoreboard;
    out_item_t                expected_q[$];
    int                       errors;
    cfg_t                     regs;
    rx_phase_e                phase;
    logic [1:0]               fld_idx;
    logic [31:0]              fld_word;
    logic [SIZE_WIDTH-1:0]    size_decl;
    logic [SIZE_WIDTH-1:0]    rx_count;
    int unsigned              blk_count;
    logic [31:0]              crc;
    logic [ELAPSED_WIDTH-1:0] elapsed;

    function new();
      errors = 0;
      regs = '{MAX_SIZE_RST, MAGIC_TO_RST, FIELD_TO_RST, BLOCK_TO_RST};
      restart();
    endfunction

    function void restart();
      begin_field(RX_MAGIC);
      size_decl = '0;
      rx_count  = '0;
      blk_count = 0;
      crc       = '1;
    endfunction

    function void begin_field(rx_phase_e ph);
      phase    = ph;
      fld_idx  = '0;
      fld_word = '0;
      elapsed  = '0;
    endfunction

    function logic [31:0] next_crc(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      int k;
      r = c;
      for (k = 0; k < 8; k++)
        r = (r[0] ^ b[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void push_verdict(logic [2:0] code, logic [SIZE_WIDTH-1:0] fsz);
      out_item_t r;
      r = '0;
      r.out_kind    = KIND_VERDICT;
      r.status_code = code;
      r.frame_size  = fsz;
      r.crc_value   = ~crc;
      expected_q.push_back(r);
      restart();
    endfunction

    function void note_input(in_item_t it);
      out_item_t             r;
      logic [15:0]           lim;
      logic [2:0]            code;
      logic [SIZE_WIDTH-1:0] fsz;
      if (it.req_type == REQ_TICK) begin
        if (elapsed != {ELAPSED_WIDTH{1'b1}}) elapsed = elapsed + 1'b1;
        fsz = '0;
        case (phase)
          RX_MAGIC: begin lim = regs.magic_timeout_ms; code = ST_MAGIC_TO; end
          RX_SIZE:  begin lim = regs.field_timeout_ms; code = ST_SIZE_TO; end
          RX_DATA:  begin
            lim = regs.block_timeout_ms; code = ST_DATA_TO; fsz = size_decl;
          end
          default:  begin
            lim = regs.field_timeout_ms; code = ST_CRC_TO; fsz = size_decl;
          end
        endcase
        if (elapsed > ELAPSED_WIDTH'(lim)) push_verdict(code, fsz);
      end else if (phase == RX_DATA) begin
        crc = next_crc(crc, it.rx_byte);
        r = '0;
        r.out_kind    = KIND_DATA;
        r.data_byte   = it.rx_byte;
        r.byte_offset = rx_count[OFFSET_WIDTH-1:0];
        expected_q.push_back(r);
        rx_count  = rx_count + 1'b1;
        blk_count = blk_count + 1;
        if (rx_count >= size_decl) begin
          blk_count = 0;
          begin_field(RX_CRC);
        end else if (blk_count >= BLOCK_BYTES_DEF) begin
          // new payload block: its own timeout window
          blk_count = 0;
          elapsed   = '0;
        end
      end else begin
        // header / trailer fields assemble little-endian
        fld_word = fld_word | (32'(it.rx_byte) << (8 * fld_idx));
        fld_idx  = fld_idx + 1'b1;
        if (fld_idx == 2'd0) begin
          case (phase)
            RX_MAGIC: begin
              if (fld_word != MAGIC_WORD) push_verdict(ST_BAD_MAGIC, '0);
              else begin_field(RX_SIZE);
            end
            RX_SIZE: begin
              if (fld_word == 0 || fld_word > 32'(regs.max_frame_size))
                push_verdict(ST_BAD_SIZE, (fld_word[31:SIZE_WIDTH] != 0) ?
                             {SIZE_WIDTH{1'b1}} : fld_word[SIZE_WIDTH-1:0]);
              else begin
                size_decl = fld_word[SIZE_WIDTH-1:0];
                begin_field(RX_DATA);
              end
            end
            default: push_verdict((fld_word == ~crc) ? ST_OK : ST_CRC_BAD, size_decl);
          endcase
        end
      end
    endfunction

    function void report(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      report("out_kind",    64'(want.out_kind),    64'(got.out_kind));
      report("data_byte",   64'(want.data_byte),   64'(got.data_byte));
      report("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
      report("status_code", 64'(want.status_code), 64'(got.status_code));
      report("frame_size",  64'(want.frame_size),  64'(got.frame_size));
      report("crc_value",   64'(want.crc_value),   64'(got.crc_value));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // parser sits at the start of a frame with a clean timeout window
    function bit fresh();
      return phase == RX_MAGIC && fld_idx == 0 && elapsed == 0;
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_data;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [SIZE_WIDTH-1:0]    cfg_wdata = '0;

  framed_image_receiver_crc32_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_scoreboard sb = new();

  bit in_burst  = 1'b0;   // sender skips its random gaps
  bit out_burst = 1'b0;   // receiver never stalls
  int beats_sent = 0;
  int cycle_cnt  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost beat ends here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == WATCHDOG_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks. All run on the posedge and drive with NBAs; a beat is
  // taken at the first edge where valid and ready are both seen high.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic kind, input logic [7:0] b);
    in_item_t it;
    int       gap;
    it.req_type = kind;
    it.rx_byte  = b;
    gap = in_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    beats_sent++;
  endtask

  task automatic send_tick();
    send_beat(REQ_TICK, 8'($urandom));
  endtask

  // byte, possibly preceded by a stray millisecond tick
  task automatic send_byte(input logic [7:0] b, input int tick_pct);
    if (tick_pct > 0 && $urandom_range(0, 99) < tick_pct) send_tick();
    send_beat(REQ_BYTE, b);
  endtask

  task automatic send_word(input logic [31:0] w, input int tick_pct);
    int i;
    for (i = 0; i < 4; i++) send_byte(w[8*i +: 8], tick_pct);
  endtask

  // Magic, size word, random payload, CRC (good or one bit flipped); only the
  // first `cut` bytes go out so truncated frames share the same path.
  task automatic send_frame(input logic [31:0] size_word, input int pay_len,
                            input bit crc_ok, input int tick_pct, input int cut);
    logic [7:0]  fb[$];
    logic [31:0] c;
    logic [7:0]  b;
    int          i;
    c = '1;
    for (i = 0; i < 4; i++) fb.push_back(MAGIC_WORD[8*i +: 8]);
    for (i = 0; i < 4; i++) fb.push_back(size_word[8*i +: 8]);
    for (i = 0; i < pay_len; i++) begin
      b = 8'($urandom);
      c = sb.next_crc(c, b);
      fb.push_back(b);
    end
    c = ~c;
    if (!crc_ok) c = c ^ (32'h1 << $urandom_range(0, 31));
    for (i = 0; i < 4; i++) fb.push_back(c[8*i +: 8]);
    for (i = 0; i < fb.size() && i < cut; i++) send_byte(fb[i], tick_pct);
  endtask

  // Close whatever frame is open using bytes only: zeros break the magic and
  // fill payload/CRC, 0xFF in the size field forces an oversize reject.
  task automatic resync();
    while (!sb.fresh())
      send_beat(REQ_BYTE, (sb.phase == RX_SIZE) ? 8'hFF : 8'h00);
  endtask

  // Mostly well-formed frames with random content; the rest is line noise,
  // corrupted magic, rejected sizes and frames cut off then timed out.
  task automatic random_traffic(input int n_beats, input int max_len,
                                input int tick_pct, input bit allow_cut);
    int          stop_at;
    int          sel;
    int          len;
    logic [31:0] sw;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      in_burst = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 12);
      if (sel < 60) begin
        send_frame(32'(len), len, $urandom_range(0, 5) != 0, tick_pct, WHOLE_FRAME);
      end else if (sel < 68) begin
        repeat ($urandom_range(1, 6)) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
      end else if (sel < 76) begin
        // one bit off in the magic
        send_word(MAGIC_WORD ^ (32'h1 << $urandom_range(0, 31)), tick_pct);
      end else if (sel < 84) begin
        case ($urandom_range(0, 3))
          0:       sw = 32'd0;
          1:       sw = 32'(sb.regs.max_frame_size) + 32'd1;
          2:       sw = $urandom;
          default: sw = 32'hFFFF_FFFF;
        endcase
        send_frame(sw, 0, 1'b1, tick_pct, 8);
      end else if (sel < 92 && allow_cut) begin
        send_frame(32'(len), len, 1'b1, tick_pct, $urandom_range(1, len + 11));
        while (!sb.fresh()) send_tick();
      end else if (sb.regs.max_frame_size <= 400 && sb.regs.max_frame_size != 0) begin
        // largest size the current limit allows
        send_frame(32'(sb.regs.max_frame_size), int'(sb.regs.max_frame_size), 1'b1,
                   tick_pct, WHOLE_FRAME);
      end else begin
        send_frame(32'(len), len, 1'b1, tick_pct, WHOLE_FRAME);
      end
    end
    resync();
  endtask

  // Let every queued result drain, then wait out the settle margin for beats still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Write all four registers back to back; only called with the block idle.
  task automatic set_regs(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_SIZE;
    cfg_wdata <= c.max_frame_size;
    @(posedge clk);
    cfg_index <= REG_MAGIC_TO;
    cfg_wdata <= SIZE_WIDTH'(c.magic_timeout_ms);
    @(posedge clk);
    cfg_index <= REG_FIELD_TO;
    cfg_wdata <= SIZE_WIDTH'(c.field_timeout_ms);
    @(posedge clk);
    cfg_index <= REG_BLOCK_TO;
    cfg_wdata <= SIZE_WIDTH'(c.block_timeout_ms);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.regs = c;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, with long stretches of none.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: one clean frame, a tick, a corrupted magic.
    send_frame(32'd2, 2, 1'b1, 0, WHOLE_FRAME);
    send_tick();
    send_word(32'h3F41_544F, 0);               // "OTA?"
    drain();

    // Zero timeouts trip on the first tick; max size 0 rejects everything.
    set_regs('{27'd0, 16'd0, 16'd0, 16'd0});
    send_tick();                                // magic timeout, no size yet
    send_frame(32'd2, 0, 1'b1, 0, 2);           // partial magic, then tick
    send_tick();
    send_frame(32'd5, 0, 1'b1, 0, 8);           // any size rejected
    send_word(MAGIC_WORD, 0);
    send_tick();                                // size timeout
    drain();

    // Smallest usable size limit with zero timeouts: data and crc timeouts.
    set_regs('{27'd1, 16'd0, 16'd0, 16'd0});
    send_frame(32'd1, 1, 1'b1, 0, 8);
    send_tick();
    send_frame(32'd1, 1, 1'b1, 0, 9);
    send_tick();
    send_frame(32'd1, 1, 1'b1, 0, WHOLE_FRAME);
    send_frame(32'd2, 0, 1'b1, 0, 8);           // one over the limit
    drain();

    // Short timeouts: the bulk of random traffic, timeouts in every phase.
    set_regs('{27'd64, 16'd4, 16'd3, 16'd6});
    random_traffic(450, 40, 8, 1'b1);
    drain();

    // Widest limits: oversize reports saturate.
    set_regs('{27'h7FF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_frame(32'hFFFF_FFFF, 0, 1'b1, 0, 8);
    send_frame(32'h0800_0000, 0, 1'b1, 0, 8);
    send_frame(32'd0, 0, 1'b1, 0, 8);
    random_traffic(200, 40, 3, 1'b0);
    drain();

    // Mid-range setting with some longer frames.
    set_regs('{27'd300, 16'd10, 16'd7, 16'd20});
    random_traffic(200, 300, 10, 1'b1);
    drain();

    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[framed_image_receiver_crc32_core.f]
hw/rtl/fircrc_pkg.sv
hw/rtl/fircrc_engine.sv
hw/rtl/framed_image_receiver_crc32_core.sv
tb/tb.sv
